@@ design/trqks_pkg.sv @@
// Shared types and constants for the task ring queue with key sort.
package trqks_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 16;

	localparam int ID_W     = 8;
	localparam int TICK_W   = 32;
	localparam int KIND_W   = 2;
	localparam int COUNT_W  = 5;

	localparam int IN_TDATA_W  = 80;
	localparam int IN_TUSER_W  = KIND_W;
	localparam int OUT_TDATA_W = 32;

	localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SORT = 2'd2;

	typedef struct packed {
		logic [TICK_W-1:0] period;
		logic [TICK_W-1:0] deadline;
		logic [ID_W-1:0]   id;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ design/trqks_ram.sv @@
// Generic simple dual-port RAM with registered read.
module trqks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ design/task_ring_queue_with_key_sort.sv @@
// Task ring queue: push, pop and stable insertion sort by deadline or period.
// Push, pop and no-op: an accepted item runs EXEC, HRD, HCAP and FIN; the result goes valid as input is ready again.
// Sort of n entries: each entry from the second onward is walked toward the head in steps;
// each step is one read, one compare and one write on the entry RAM.
// One item in flight; while a result waits, the next item runs but its result holds until taken.
// Reset (arst_n low, asynchronous) empties the queue and head; entry RAM contents are not cleared.
module task_ring_queue_with_key_sort #(
	parameter int QUEUE_DEPTH = trqks_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// task_id[7:0], task_deadline[39:8], task_period[71:40], sort_key[72], zero fill
	input  logic [trqks_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// kind[1:0]
	input  logic [trqks_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// popped_id[7:0], popped_valid[8], push_accepted[9], entry_count[14:10],
	// head_id[22:15], is_empty[23], is_full[24], zero fill
	output logic [trqks_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	import trqks_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_EXEC = 10'b0000000010,
		ST_RDI  = 10'b0000000100,
		ST_GETI = 10'b0000001000,
		ST_RDJ  = 10'b0000010000,
		ST_CMP  = 10'b0000100000,
		ST_PUT  = 10'b0001000000,
		ST_HRD  = 10'b0010000000,
		ST_HCAP = 10'b0100000000,
		ST_FIN  = 10'b1000000000
	} state_t;

	function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
	                                              input logic [IDX_W-1:0] off);
		logic [IDX_W:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (IDX_W+1)'(QUEUE_DEPTH)) begin
			s = s - (IDX_W+1)'(QUEUE_DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	state_t            state_q;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  occ_q;
	logic [KIND_W-1:0] kind_q;
	entry_t            ent_q;
	logic              key_q;
	entry_t            cur_q;
	logic [IDX_W-1:0]  i_q;
	logic [IDX_W-1:0]  j_q;
	logic [ID_W-1:0]   head_id_q;
	logic [ID_W-1:0]   pop_id_q;
	logic              pop_vld_q;
	logic              push_acc_q;
	logic              m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	logic              ram_we;
	logic [IDX_W-1:0]  wr_off;
	logic [IDX_W-1:0]  rd_off;
	logic [IDX_W-1:0]  wr_pos;
	logic [IDX_W-1:0]  rd_pos;
	entry_t            ram_wd;
	entry_t            ram_rd;
	logic              move_up;
	logic              full;
	logic              i_last;
	logic              out_free;
	logic              in_fire;
	logic [ID_W-1:0]   head_id_out;

	trqks_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(wr_pos),
		.wr_data(ram_wd),
		.rd_addr(rd_pos),
		.rd_data(ram_rd)
	);

	assign full     = (occ_q == CNT_W'(QUEUE_DEPTH));
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign i_last   = ((CNT_W'(i_q) + CNT_W'(1)) == occ_q);
	assign move_up  = key_q ? (ram_rd.period > cur_q.period)
	                        : (ram_rd.deadline > cur_q.deadline);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	always_comb begin
		wr_off = j_q;
		rd_off = '0;
		ram_we = 1'b0;
		ram_wd = cur_q;
		case (state_q)
			ST_EXEC: begin
				wr_off = (kind_q == KIND_POP) ? IDX_W'(1) : occ_q[IDX_W-1:0];
				ram_we = (kind_q == KIND_PUSH) && !full;
				ram_wd = ent_q;
			end
			ST_RDI: rd_off = i_q;
			ST_RDJ: rd_off = j_q - IDX_W'(1);
			ST_CMP: begin
				ram_we = 1'b1;
				ram_wd = move_up ? ram_rd : cur_q;
			end
			ST_PUT: ram_we = 1'b1;
			default: ;
		endcase
	end

	assign wr_pos = ring_pos(head_q, wr_off);
	assign rd_pos = ring_pos(head_q, rd_off);

	assign head_id_out = (occ_q != '0) ? head_id_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			occ_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ((kind_q == KIND_SORT) && (occ_q > CNT_W'(1))) ? ST_RDI : ST_HRD;
					if (kind_q == KIND_PUSH) begin
						if (!full) begin
							occ_q <= occ_q + CNT_W'(1);
						end
					end else if (kind_q == KIND_POP) begin
						if (occ_q != '0) begin
							head_q <= wr_pos;
							occ_q  <= occ_q - CNT_W'(1);
						end
					end
				end
				ST_RDI:  state_q <= ST_GETI;
				ST_GETI: state_q <= ST_RDJ;
				ST_RDJ:  state_q <= ST_CMP;
				ST_CMP: begin
					if (move_up) begin
						state_q <= (j_q == IDX_W'(1)) ? ST_PUT : ST_RDJ;
					end else begin
						state_q <= i_last ? ST_HRD : ST_RDI;
					end
				end
				ST_PUT:  state_q <= i_last ? ST_HRD : ST_RDI;
				ST_HRD:  state_q <= ST_HCAP;
				ST_HCAP: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					kind_q      <= s_axis_tuser[KIND_W-1:0];
					ent_q       <= {s_axis_tdata[71:40], s_axis_tdata[39:8], s_axis_tdata[7:0]};
					key_q       <= s_axis_tdata[72];
				end
			end
			ST_EXEC: begin
				pop_vld_q  <= (kind_q == KIND_POP) && (occ_q != '0);
				pop_id_q   <= ((kind_q == KIND_POP) && (occ_q != '0)) ? head_id_q : '0;
				push_acc_q <= (kind_q == KIND_PUSH) && !full;
				i_q        <= IDX_W'(1);
			end
			ST_GETI: begin
				cur_q <= ram_rd;
				j_q   <= i_q;
			end
			ST_CMP: begin
				if (move_up) begin
					j_q <= j_q - IDX_W'(1);
				end else begin
					i_q <= i_q + IDX_W'(1);
				end
			end
			ST_PUT: i_q <= i_q + IDX_W'(1);
			ST_HCAP: head_id_q <= ram_rd.id;
			ST_FIN: begin
				if (out_free) begin
					m_data_q <= {7'd0, full, (occ_q == '0), head_id_out, COUNT_W'(occ_q),
					             push_acc_q, pop_vld_q, pop_id_q};
				end
			end
			default: ;
		endcase
	end

endmodule
